### rtl/core/mlbpg_pkg.sv
`default_nettype none

package mlbpg_pkg;

    localparam int unsigned MAX_LEDS  = 8;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned MODE_W    = 3;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned INDEX_W   = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] TICK_STEP_RST  = 16'd10;
    localparam logic [CFG_W-1:0] SLOW_LIMIT_RST = 16'd500;
    localparam logic [CFG_W-1:0] FAST_LIMIT_RST = 16'd100;

    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_SET  = 1'b1
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF     = 3'd0,
        MODE_ON      = 3'd1,
        MODE_SLOW    = 3'd2,
        MODE_FAST    = 3'd3,
        MODE_DOUBLE  = 3'd4,
        MODE_TRIPLE  = 3'd5,
        MODE_DASHDOT = 3'd6,
        MODE_INVALID = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_MODE  = 2'd1,
        STATUS_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_STEP  = 2'd0,
        CFG_SLOW_LIMIT = 2'd1,
        CFG_FAST_LIMIT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_SET  = 2'd1,
        SEQ_TICK = 2'd2,
        SEQ_DONE = 2'd3
    } seq_state_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [PHASE_W-1:0] phase;
        logic [CFG_W-1:0]   count;
        logic               lit;
    } led_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] tick_step;
        logic [CFG_W-1:0] slow_limit;
        logic [CFG_W-1:0] fast_limit;
    } cfg_t;

    // number of phases in a pattern
    function automatic logic [PHASE_W:0] phase_total(input logic [MODE_W-1:0] m);
        logic [PHASE_W:0] r;
        begin
            case (m)
                MODE_SLOW:    r = 4'd2;
                MODE_FAST:    r = 4'd2;
                MODE_DOUBLE:  r = 4'd5;
                MODE_TRIPLE:  r = 4'd7;
                MODE_DASHDOT: r = 4'd4;
                default:      r = 4'd0;
            endcase
            return r;
        end
    endfunction

    // lit level per phase, bit p is phase p
    function automatic logic [7:0] phase_level(input logic [MODE_W-1:0] m);
        logic [7:0] r;
        begin
            case (m)
                MODE_SLOW:    r = 8'h01;
                MODE_FAST:    r = 8'h01;
                MODE_DOUBLE:  r = 8'h05;
                MODE_TRIPLE:  r = 8'h15;
                MODE_DASHDOT: r = 8'h05;
                default:      r = 8'h00;
            endcase
            return r;
        end
    endfunction

    // phases timed by the slow limit
    function automatic logic [7:0] phase_slow(input logic [MODE_W-1:0] m);
        logic [7:0] r;
        begin
            case (m)
                MODE_SLOW:    r = 8'h03;
                MODE_DOUBLE:  r = 8'h10;
                MODE_DASHDOT: r = 8'h09;
                default:      r = 8'h00;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/mlbpg_in_if.sv
`default_nettype none

interface mlbpg_in_if;
    import mlbpg_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [INDEX_W-1:0]  led_index;
    logic [MODE_W-1:0]   mode_request;

    modport source (output valid, output op, output led_index, output mode_request,
                    input ready);
    modport sink   (input valid, input op, input led_index, input mode_request,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/mlbpg_out_if.sv
`default_nettype none

interface mlbpg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] led_bits;
    logic [1:0] status;

    modport source (output valid, output led_bits, output status, input ready);
    modport sink   (input valid, input led_bits, input status, output ready);
endinterface

`default_nettype wire

### rtl/core/multi_led_blink_pattern_generator_core.sv
// Multi-LED blink pattern generator.
// Input channel "item" (valid/ready): op 0 is a tick that advances every LED's
// pattern, op 1 sets the mode of LED led_index to mode_request.
// Output channel "result" (valid/ready): one word per input word. A tick gives
// the lit bits of all LEDs in led_bits with status ok; a set gives led_bits 0
// and status ok, bad mode (checked first) or bad index.
// Config port: cfg_we/cfg_index/cfg_data writes tick_step (0), slow_limit (1)
// or fast_limit (2); other indexes are ignored. Write only while idle.
// Sequencing: a tick walks the LEDs one per cycle through a single shared phase
// engine, then the done state loads the output register once it is free; a set
// passes through the set and done states. One word is in flight at a time;
// ready is high only while the sequencer is idle.
// The result sits in an output register, so the next word is accepted while
// a result is still waiting; if the receiver stalls long enough the sequencer
// holds the finished result in its done state and stays busy.
// Reset: all LEDs off with phase, count and lit cleared; config registers
// return to 10/500/100; no result pending.
`default_nettype none

module multi_led_blink_pattern_generator_core #(
    parameter int unsigned LED_COUNT = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mlbpg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mlbpg_pkg::CFG_W-1:0]         cfg_data,
    mlbpg_in_if.sink                            item,
    mlbpg_out_if.source                         result
);
    import mlbpg_pkg::*;

    localparam int unsigned IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [IDX_W-1:0]   LAST_LED  = IDX_W'(LED_COUNT - 1);
    localparam logic [INDEX_W-1:0] LED_LIMIT = INDEX_W'(LED_COUNT);

    // config registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_step  <= TICK_STEP_RST;
            cfg_reg.slow_limit <= SLOW_LIMIT_RST;
            cfg_reg.fast_limit <= FAST_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TICK_STEP:  cfg_reg.tick_step  <= cfg_data;
                CFG_SLOW_LIMIT: cfg_reg.slow_limit <= cfg_data;
                CFG_FAST_LIMIT: cfg_reg.fast_limit <= cfg_data;
                default:        ;
            endcase
        end
    end

    // sequencer and datapath registers
    seq_state_t          state_reg, state_next;
    logic                op_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [MODE_W-1:0]   mode_req_reg;
    logic [IDX_W-1:0]    led_ptr_reg, led_ptr_next;
    logic [7:0]          bits_reg, bits_next;
    logic [1:0]          status_reg, status_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_bits_reg;
    logic [1:0]          out_status_reg;

    // per-LED state
    led_state_t          led_reg [LED_COUNT];
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    rd_addr;
    led_state_t          rd_data;
    led_state_t          wr_data;
    led_state_t          unit_nxt;
    logic                unit_bit;

    logic                accept;
    logic                out_free;
    logic                load_out;
    logic                set_ok;

    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign set_ok   = (mode_req_reg != MODE_INVALID) && (idx_reg < LED_LIMIT);

    assign rd_addr = (state_reg == SEQ_TICK) ? led_ptr_reg : idx_reg[IDX_W-1:0];
    assign rd_data = led_reg[rd_addr];

    mlbpg_led_unit u_unit (
        .cur     (rd_data),
        .cfg     (cfg_reg),
        .nxt     (unit_nxt),
        .bit_out (unit_bit)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                    state_next = (item.op == OP_SET) ? SEQ_SET : SEQ_TICK;
            end
            SEQ_SET:
            begin
                state_next = SEQ_DONE;
            end
            SEQ_TICK:
            begin
                if (led_ptr_reg == LAST_LED)
                    state_next = SEQ_DONE;
            end
            SEQ_DONE:
            begin
                if (out_free)
                    state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        item.ready   = 1'b0;
        load_out     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = rd_addr;
        wr_data      = unit_nxt;
        led_ptr_next = led_ptr_reg;
        bits_next    = bits_reg;
        status_next  = status_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                item.ready   = 1'b1;
                led_ptr_next = '0;
                bits_next    = '0;
                status_next  = STATUS_OK;
            end
            SEQ_SET:
            begin
                if (mode_req_reg == MODE_INVALID)
                    status_next = STATUS_BAD_MODE;
                else if (idx_reg >= LED_LIMIT)
                    status_next = STATUS_BAD_INDEX;
                else
                    status_next = STATUS_OK;
                wr_en         = set_ok;
                wr_data.mode  = mode_req_reg;
                wr_data.phase = '0;
                wr_data.count = '0;
                wr_data.lit   = rd_data.lit;
            end
            SEQ_TICK:
            begin
                wr_en                 = 1'b1;
                bits_next[led_ptr_reg] = unit_bit;
                led_ptr_next          = led_ptr_reg + IDX_W'(1);
            end
            SEQ_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            out_valid_reg <= 1'b0;
            led_ptr_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            led_ptr_reg   <= led_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg   <= bits_next;
        status_reg <= status_next;
        if (accept)
        begin
            op_reg       <= item.op;
            idx_reg      <= item.led_index;
            mode_req_reg <= item.mode_request;
        end
        if (load_out)
        begin
            // a set reports no lit bits
            out_bits_reg   <= (op_reg == OP_SET) ? 8'h00 : bits_reg;
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LED_COUNT; i++)
                led_reg[i] <= '0;
        end
        else if (wr_en)
        begin
            led_reg[wr_addr] <= wr_data;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.led_bits = out_bits_reg;
    assign result.status   = out_status_reg;

endmodule

`default_nettype wire

### rtl/core/mlbpg_led_unit.sv
`default_nettype none

// Shared phase engine: advances one LED per use.
module mlbpg_led_unit (
    input  mlbpg_pkg::led_state_t cur,
    input  mlbpg_pkg::cfg_t       cfg,
    output mlbpg_pkg::led_state_t nxt,
    output logic                  bit_out
);
    import mlbpg_pkg::*;

    logic [PHASE_W:0]  total;
    logic [7:0]        level;
    logic [7:0]        slow;
    logic [CFG_W:0]    sum;
    logic [CFG_W-1:0]  sat;
    logic [CFG_W-1:0]  limit;
    logic [PHASE_W:0]  p_inc;

    always_comb
    begin
        total = phase_total(cur.mode);
        level = phase_level(cur.mode);
        slow  = phase_slow(cur.mode);
        sum   = {1'b0, cur.count} + {1'b0, cfg.tick_step};
        sat   = sum[CFG_W] ? {CFG_W{1'b1}} : sum[CFG_W-1:0];
        limit = slow[cur.phase] ? cfg.slow_limit : cfg.fast_limit;
        p_inc = {1'b0, cur.phase} + {{PHASE_W{1'b0}}, 1'b1};

        nxt     = cur;
        bit_out = 1'b0;
        case (cur.mode)
            MODE_INVALID:
            begin
                nxt.mode = MODE_OFF;
            end
            MODE_OFF:
            begin
                nxt.lit = 1'b0;
            end
            MODE_ON:
            begin
                nxt.lit = 1'b1;
                bit_out = 1'b1;
            end
            default:
            begin
                if ({1'b0, cur.phase} >= total)
                begin
                    nxt.phase = '0;
                    bit_out   = cur.lit;
                end
                else
                begin
                    nxt.lit = level[cur.phase];
                    bit_out = level[cur.phase];
                    if (sat >= limit)
                    begin
                        nxt.count = '0;
                        nxt.phase = (p_inc >= total) ? '0 : p_inc[PHASE_W-1:0];
                    end
                    else
                    begin
                        nxt.count = sat;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/mlbpg_checker.sv
`default_nettype none

module mlbpg_assertions (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] led_bits,
    input logic [1:0] status
);
    import mlbpg_pkg::*;

    // busy right after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a word back to back");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_BAD_MODE ||
                       status == STATUS_BAD_INDEX))
        else $error("illegal status code");

    a_error_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> led_bits == 8'h00)
        else $error("failed set shows lit bits");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(led_bits) && $stable(status))
        else $error("stalled result changed");

endmodule

bind multi_led_blink_pattern_generator_core mlbpg_assertions u_mlbpg_assertions (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .led_bits  (result.led_bits),
    .status    (result.status)
);

`default_nettype wire
